FILE: rtl/mdta_pkg.sv
// shared types and constants of the threshold alarm block
// no dependencies; imported by mdta_store, mdta_update, the top level and the verif files
package mdta_pkg;

   // per-channel over-threshold time, in ms
   localparam int unsigned TIME_W = 17;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [TIME_W-1:0] DEFAULT_HOLD_MS = 17'd1000;

   // op codes of an input word
   localparam logic [1:0] OP_SAMPLE      = 2'd0;
   localparam logic [1:0] OP_CFG_CHANGED = 2'd1;
   localparam logic [1:0] OP_FULL_RESET  = 2'd2;

   // channel and system phases
   localparam logic [1:0] PH_NORMAL     = 2'd0;
   localparam logic [1:0] PH_TRIGGERING = 2'd1;
   localparam logic [1:0] PH_ALARM      = 2'd2;

   // write-back command toward the channel store
   typedef struct packed {
      logic wr_en;
      logic set_latch;
      logic clr_timers;
      logic clr_all;
   } store_cmd_type;

   // outcome of one word for the frame logic
   typedef struct packed {
      logic [1:0] phase;
      logic       trig;
      logic       latched;
      logic       frame_close;
   } chan_result_type;

endpackage

FILE: rtl/multichannel_debounced_threshold_alarm_top.sv
// top level of the multichannel time-qualified threshold alarm
// depends on mdta_pkg, mdta_store and mdta_update
//
//   channel  direction  handshake         payload
//   req_     in         valid / stall     op, channel, sample_value, alarm_level,
//                                         hold_ms, elapsed_ms, last_in_frame
//   rsp_     out        valid / stall     channel_phase, frame_done, system_status,
//                                         general_active, popup_rise, alarm_channel
//
// one word per cycle sustained while rsp is not held; the accepting edge loads the
// store read register with the channel's time; the update stage then updates it,
// writes it back and loads the output register once that is free, raising rsp_valid;
// a write to the channel being read at the same edge is forwarded into the read register
// reset is synchronous; per-channel valid and latch bits clear at once, so no
// clearing pass follows reset
// a held rsp word stalls the update stage, which in turn stalls req
module multichannel_debounced_threshold_alarm_top #(
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_channel,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_alarm_level,
   input  logic [15:0]        req_hold_ms,
   input  logic [15:0]        req_elapsed_ms,
   input  logic               req_last_in_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_channel_phase,
   output logic               rsp_frame_done,
   output logic [1:0]         rsp_system_status,
   output logic               rsp_general_active,
   output logic               rsp_popup_rise,
   output logic [3:0]         rsp_alarm_channel
);
   import mdta_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // handshake
   logic req_take;
   logic out_free;
   logic commit;

   // update stage
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [1:0]         s1_op_ff;
   logic [3:0]         s1_ch_ff;
   logic               s1_ok_ff;
   logic signed [31:0] s1_val_ff;
   logic signed [31:0] s1_lvl_ff;
   logic [15:0]        s1_hold_ff;
   logic [15:0]        s1_dt_ff;
   logic               s1_last_ff;

   // store interface
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     cur_addr;
   logic [TIME_W-1:0] cur_time;
   logic              cur_latch;
   logic [TIME_W-1:0] wr_time;
   store_cmd_type     upd_cmd;
   store_cmd_type     cmd;
   chan_result_type   res;

   // frame summary state
   logic       any_trig_ff,  any_trig_in;
   logic       any_latch_ff, any_latch_in;
   logic       prev_gen_ff,  prev_gen_in;
   logic [3:0] recent_ch_ff, recent_ch_in;
   logic       trig_upd;
   logic       latch_upd;
   logic [3:0] recent_upd;

   // output register
   logic       rsp_valid_ff,    rsp_valid_in;
   logic [1:0] rsp_phase_ff,    rsp_phase_in;
   logic       rsp_done_ff,     rsp_done_in;
   logic [1:0] rsp_status_ff,   rsp_status_in;
   logic       rsp_general_ff,  rsp_general_in;
   logic       rsp_popup_ff,    rsp_popup_in;
   logic [3:0] rsp_alarm_ch_ff, rsp_alarm_ch_in;

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in = req_take || (s1_valid_ff && !commit);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // capture the word while its store read is in flight
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_op;
         s1_ch_ff   <= req_channel;
         s1_ok_ff   <= ({28'd0, req_channel} < 32'(CHANNELS));
         s1_val_ff  <= req_sample_value;
         s1_lvl_ff  <= req_alarm_level;
         s1_hold_ff <= req_hold_ms;
         s1_dt_ff   <= req_elapsed_ms;
         s1_last_ff <= req_last_in_frame;
      end
   end

   assign rd_addr  = AW'(req_channel);
   assign cur_addr = AW'(s1_ch_ff);
   assign cmd      = commit ? upd_cmd : '0;

   mdta_store #(
      .CHANNELS (CHANNELS),
      .AW       (AW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_addr   (rd_addr),
      .cur_addr  (cur_addr),
      .cmd       (cmd),
      .wr_addr   (cur_addr),
      .wr_time   (wr_time),
      .cur_time  (cur_time),
      .cur_latch (cur_latch)
   );

   mdta_update u_update (
      .op            (s1_op_ff),
      .ch_ok         (s1_ok_ff),
      .sample_value  (s1_val_ff),
      .alarm_level   (s1_lvl_ff),
      .hold_ms       (s1_hold_ff),
      .elapsed_ms    (s1_dt_ff),
      .last_in_frame (s1_last_ff),
      .cur_time      (cur_time),
      .cur_latch     (cur_latch),
      .cmd           (upd_cmd),
      .wr_time       (wr_time),
      .res           (res)
   );

   // frame merge and close-out
   always_comb begin
      trig_upd   = any_trig_ff || res.trig;
      latch_upd  = any_latch_ff || res.latched;
      recent_upd = res.latched ? s1_ch_ff : recent_ch_ff;

      any_trig_in  = any_trig_ff;
      any_latch_in = any_latch_ff;
      prev_gen_in  = prev_gen_ff;
      recent_ch_in = recent_ch_ff;

      rsp_phase_in    = res.phase;
      rsp_done_in     = 1'b0;
      rsp_status_in   = PH_NORMAL;
      rsp_general_in  = 1'b0;
      rsp_popup_in    = 1'b0;
      rsp_alarm_ch_in = 4'd0;

      if (upd_cmd.clr_all) begin
         any_trig_in  = 1'b0;
         any_latch_in = 1'b0;
         prev_gen_in  = 1'b0;
         recent_ch_in = 4'd0;
      end else if (res.frame_close) begin
         any_trig_in  = 1'b0;
         any_latch_in = 1'b0;
         prev_gen_in  = latch_upd;
         recent_ch_in = recent_upd;

         rsp_done_in    = 1'b1;
         rsp_general_in = latch_upd;
         rsp_popup_in   = latch_upd && !prev_gen_ff;
         if (latch_upd) begin
            rsp_status_in   = PH_ALARM;
            rsp_alarm_ch_in = recent_upd;
         end else if (trig_upd) begin
            rsp_status_in = PH_TRIGGERING;
         end
      end else begin
         any_trig_in  = trig_upd;
         any_latch_in = latch_upd;
         recent_ch_in = recent_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_trig_ff  <= 1'b0;
         any_latch_ff <= 1'b0;
         prev_gen_ff  <= 1'b0;
         recent_ch_ff <= 4'd0;
      end else if (commit) begin
         any_trig_ff  <= any_trig_in;
         any_latch_ff <= any_latch_in;
         prev_gen_ff  <= prev_gen_in;
         recent_ch_ff <= recent_ch_in;
      end
   end

   // output word register
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_phase_ff    <= rsp_phase_in;
         rsp_done_ff     <= rsp_done_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_general_ff  <= rsp_general_in;
         rsp_popup_ff    <= rsp_popup_in;
         rsp_alarm_ch_ff <= rsp_alarm_ch_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_phase  = rsp_phase_ff;
   assign rsp_frame_done     = rsp_done_ff;
   assign rsp_system_status  = rsp_status_ff;
   assign rsp_general_active = rsp_general_ff;
   assign rsp_popup_rise     = rsp_popup_ff;
   assign rsp_alarm_channel  = rsp_alarm_ch_ff;

`ifndef SYNTHESIS
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_valid_ff))
      else $error("req stalled without a held output word");
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |->
         (rsp_status_ff == PH_NORMAL) && !rsp_general_ff && !rsp_popup_ff &&
         (rsp_alarm_ch_ff == 4'd0))
      else $error("summary fields set outside a frame close");
   a_general_matches_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_general_ff == (rsp_status_ff == PH_ALARM)))
      else $error("general flag disagrees with system status");
   a_full_reset_frame: assert property (@(posedge clock) disable iff (reset)
      (commit && upd_cmd.clr_all) |=> (!any_latch_ff && !any_trig_ff && !prev_gen_ff))
      else $error("frame state survived a full reset");
`endif

endmodule

FILE: rtl/mdta_store.sv
// channel state store: over-threshold time memory plus valid and latch bits
// depends on mdta_pkg
module mdta_store #(
   parameter int CHANNELS = 16,
   parameter int AW       = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   input  logic [AW-1:0]                cur_addr,
   input  mdta_pkg::store_cmd_type      cmd,
   input  logic [AW-1:0]                wr_addr,
   input  logic [mdta_pkg::TIME_W-1:0]  wr_time,
   output logic [mdta_pkg::TIME_W-1:0]  cur_time,
   output logic                         cur_latch
);
   import mdta_pkg::*;

   logic [TIME_W-1:0]   time_mem [CHANNELS];
   logic [TIME_W-1:0]   rd_time_ff;
   logic [CHANNELS-1:0] vld_ff;
   logic [CHANNELS-1:0] vld_in;
   logic [CHANNELS-1:0] latch_ff;
   logic [CHANNELS-1:0] latch_in;

   // memory write, registered read with forwarding of a same-edge write
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         time_mem[wr_addr] <= wr_time;
      end
      if (rd_en) begin
         if (cmd.wr_en && (wr_addr == rd_addr)) begin
            rd_time_ff <= wr_time;
         end else begin
            rd_time_ff <= time_mem[rd_addr];
         end
      end
   end

   // valid and latch bits: clears hit all channels at once
   always_comb begin
      vld_in   = vld_ff;
      latch_in = latch_ff;
      if (cmd.clr_all || cmd.clr_timers) begin
         vld_in = '0;
      end
      if (cmd.clr_all) begin
         latch_in = '0;
      end
      if (cmd.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (cmd.set_latch) begin
         latch_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         latch_ff <= '0;
      end else begin
         vld_ff   <= vld_in;
         latch_ff <= latch_in;
      end
   end

   // an entry not written since the last clear reads as zero time
   assign cur_time  = vld_ff[cur_addr] ? rd_time_ff : '0;
   assign cur_latch = latch_ff[cur_addr];

`ifndef SYNTHESIS
   a_clear_drops_latches: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_all |=> (latch_ff == '0))
      else $error("latch survived a full reset");
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> vld_ff[$past(wr_addr)])
      else $error("written entry not marked valid");
   a_no_write_on_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !(cmd.clr_all || cmd.clr_timers))
      else $error("write and clear in the same cycle");
`endif

endmodule

FILE: rtl/mdta_update.sv
// per-word channel update: threshold compare, saturating time add, latch decision
// depends on mdta_pkg
module mdta_update (
   input  logic [1:0]                   op,
   input  logic                         ch_ok,
   input  logic signed [31:0]           sample_value,
   input  logic signed [31:0]           alarm_level,
   input  logic [15:0]                  hold_ms,
   input  logic [15:0]                  elapsed_ms,
   input  logic                         last_in_frame,
   input  logic [mdta_pkg::TIME_W-1:0]  cur_time,
   input  logic                         cur_latch,
   output mdta_pkg::store_cmd_type      cmd,
   output logic [mdta_pkg::TIME_W-1:0]  wr_time,
   output mdta_pkg::chan_result_type    res
);
   import mdta_pkg::*;

   logic              sample_go;
   logic              over;
   logic [TIME_W-1:0] need;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] sat;
   logic [TIME_W-1:0] post_time;
   logic              post_latch;
   logic [1:0]        phase;

   always_comb begin
      sample_go = (op == OP_SAMPLE) && (elapsed_ms != 16'd0);
      over      = sample_value >= alarm_level;
      need      = (hold_ms == 16'd0) ? DEFAULT_HOLD_MS : {1'b0, hold_ms};

      // saturating accumulate of the over-threshold time
      sum = {1'b0, cur_time} + (TIME_W + 1)'(elapsed_ms);
      sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

      cmd        = '0;
      wr_time    = over ? sat : '0;
      post_time  = cur_time;
      post_latch = cur_latch;

      case (op)
         OP_SAMPLE: begin
            if (sample_go && ch_ok && !cur_latch) begin
               cmd.wr_en = 1'b1;
               post_time = wr_time;
               if (over && (sat >= need)) begin
                  cmd.set_latch = 1'b1;
                  post_latch    = 1'b1;
               end
            end
         end
         OP_CFG_CHANGED: begin
            cmd.clr_timers = 1'b1;
            post_time      = '0;
         end
         OP_FULL_RESET: begin
            cmd.clr_all = 1'b1;
            post_time   = '0;
            post_latch  = 1'b0;
         end
         default: begin
         end
      endcase

      // phase follows from latch and time: nonzero time means triggering
      if (!ch_ok) begin
         phase = PH_NORMAL;
      end else if (post_latch) begin
         phase = PH_ALARM;
      end else if (post_time != '0) begin
         phase = PH_TRIGGERING;
      end else begin
         phase = PH_NORMAL;
      end

      res.phase       = phase;
      res.trig        = sample_go && ch_ok && (phase == PH_TRIGGERING);
      res.latched     = sample_go && ch_ok && post_latch;
      res.frame_close = sample_go && last_in_frame;
   end

endmodule

FILE: verif/alarm_status_checker.sv
`timescale 1ns / 1ps
// response checker for the threshold alarm block: tracks channel state per accepted word
// and compares every response word with the predicted one; depends on mdta_pkg
module alarm_status_checker #(
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_channel,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_alarm_level,
   input  logic [15:0]        req_hold_ms,
   input  logic [15:0]        req_elapsed_ms,
   input  logic               req_last_in_frame,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_channel_phase,
   input  logic               rsp_frame_done,
   input  logic [1:0]         rsp_system_status,
   input  logic               rsp_general_active,
   input  logic               rsp_popup_rise,
   input  logic [3:0]         rsp_alarm_channel,
   output int                 mismatch_count,
   output int                 words_in_flight
);
   import mdta_pkg::*;

   typedef struct packed {
      logic [1:0] channel_phase;
      logic       frame_done;
      logic [1:0] system_status;
      logic       general_active;
      logic       popup_rise;
      logic [3:0] alarm_channel;
   } status_word_type;

   // predicted channel and frame state
   logic [TIME_W-1:0] over_ms [CHANNELS];
   logic              latched [CHANNELS];
   logic [1:0]        chan_phase [CHANNELS];
   logic              frame_trig;
   logic              frame_latch;
   logic              prev_general;
   logic [3:0]        last_alarm_ch;

   status_word_type expected_status_q [$];
   int mismatches = 0;

   task automatic clear_alarm_state();
      for (int i = 0; i < CHANNELS; i++) begin
         over_ms[i] = '0;
         latched[i] = 1'b0;
         chan_phase[i] = PH_NORMAL;
      end
      frame_trig = 1'b0;
      frame_latch = 1'b0;
      prev_general = 1'b0;
      last_alarm_ch = '0;
   endtask

   // advance the predicted state by one input word and form its response word
   task automatic predict_status(input logic [1:0] op, input logic [3:0] ch,
                                 input logic signed [31:0] val,
                                 input logic signed [31:0] lvl,
                                 input logic [15:0] hold, input logic [15:0] elapsed,
                                 input logic last, output status_word_type w);
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] need;
      logic              over;
      w = '0;
      if (op == OP_FULL_RESET) begin
         clear_alarm_state();
      end else if (op == OP_CFG_CHANGED) begin
         for (int i = 0; i < CHANNELS; i++) begin
            over_ms[i] = '0;
            if (!latched[i]) chan_phase[i] = PH_NORMAL;
         end
      end else if (op == OP_SAMPLE && elapsed != 16'd0) begin
         if (ch < CHANNELS) begin
            over = (val >= lvl);
            need = (hold == 16'd0) ? DEFAULT_HOLD_MS : TIME_W'(hold);
            if (latched[ch]) begin
               chan_phase[ch] = PH_ALARM;
            end else if (!over) begin
               over_ms[ch] = '0;
               chan_phase[ch] = PH_NORMAL;
            end else begin
               // saturating accumulate of over-threshold time
               sum = {1'b0, over_ms[ch]} + (TIME_W + 1)'(elapsed);
               if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
               over_ms[ch] = sum[TIME_W-1:0];
               if (sum >= {1'b0, need}) begin
                  latched[ch] = 1'b1;
                  chan_phase[ch] = PH_ALARM;
               end else begin
                  chan_phase[ch] = PH_TRIGGERING;
               end
            end
            if (chan_phase[ch] == PH_TRIGGERING) frame_trig = 1'b1;
            if (latched[ch]) begin
               frame_latch = 1'b1;
               last_alarm_ch = ch;
            end
         end
         // frame close: merged summary, then open a new frame
         if (last) begin
            w.frame_done = 1'b1;
            w.system_status = frame_latch ? PH_ALARM :
                              (frame_trig ? PH_TRIGGERING : PH_NORMAL);
            w.general_active = frame_latch;
            w.popup_rise = frame_latch && !prev_general;
            w.alarm_channel = frame_latch ? last_alarm_ch : 4'd0;
            prev_general = frame_latch;
            frame_trig = 1'b0;
            frame_latch = 1'b0;
         end
      end
      w.channel_phase = (ch < CHANNELS) ? chan_phase[ch] : PH_NORMAL;
   endtask

   task automatic note_mismatch(input logic have_want, input status_word_type want,
                                input status_word_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         if (have_want)
            $display({"%0t: mismatch: expected phase %0d done %0b status %0d",
                      " general %0b popup %0b alarm_ch %0d"},
                     $realtime, want.channel_phase, want.frame_done, want.system_status,
                     want.general_active, want.popup_rise, want.alarm_channel);
         else
            $display("%0t: response word with nothing pending", $realtime);
         $display({"%0t:   actual phase %0d done %0b status %0d",
                   " general %0b popup %0b alarm_ch %0d"},
                  $realtime, seen.channel_phase, seen.frame_done, seen.system_status,
                  seen.general_active, seen.popup_rise, seen.alarm_channel);
      end
   endtask

   // responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      status_word_type seen, want;
      if (reset) begin
         clear_alarm_state();
         expected_status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_channel_phase, rsp_frame_done, rsp_system_status,
                    rsp_general_active, rsp_popup_rise, rsp_alarm_channel};
            if (expected_status_q.size() == 0) begin
               note_mismatch(1'b0, '0, seen);
            end else begin
               want = expected_status_q.pop_front();
               if (seen.channel_phase !== want.channel_phase ||
                   seen.frame_done !== want.frame_done ||
                   seen.system_status !== want.system_status ||
                   seen.general_active !== want.general_active ||
                   seen.popup_rise !== want.popup_rise ||
                   seen.alarm_channel !== want.alarm_channel)
                  note_mismatch(1'b1, want, seen);
            end
         end
         if (req_valid && !req_stall) begin
            predict_status(req_op, req_channel, req_sample_value, req_alarm_level,
                           req_hold_ms, req_elapsed_ms, req_last_in_frame, want);
            expected_status_q.push_back(want);
         end
      end
      mismatch_count <= mismatches;
      words_in_flight <= expected_status_q.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// top of the threshold alarm testbench: clock, reset, stimulus, stalls and verdict
// depends on mdta_pkg, multichannel_debounced_threshold_alarm_top and alarm_status_checker
module testbench;
   import mdta_pkg::*;

   localparam int CHANNELS = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 208;
   localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S_MIN = 32'h8000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = OP_SAMPLE;
   logic [3:0]         req_channel = '0;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_alarm_level = '0;
   logic [15:0]        req_hold_ms = '0;
   logic [15:0]        req_elapsed_ms = '0;
   logic               req_last_in_frame = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_channel_phase;
   logic               rsp_frame_done;
   logic [1:0]         rsp_system_status;
   logic               rsp_general_active;
   logic               rsp_popup_rise;
   logic [3:0]         rsp_alarm_channel;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int mismatch_count;
   int words_in_flight;
   logic signed [31:0] chan_level [CHANNELS];

   multichannel_debounced_threshold_alarm_top #(.CHANNELS(CHANNELS)) DUT (.*);

   alarm_status_checker #(.CHANNELS(CHANNELS)) checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one word, with random idle cycles ahead of it, and wait for acceptance
   task automatic push_word(input logic [1:0] op, input logic [3:0] ch,
                            input logic [31:0] val, input logic [31:0] lvl,
                            input logic [15:0] hold, input logic [15:0] elapsed,
                            input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_channel <= ch;
      req_sample_value <= val;
      req_alarm_level <= lvl;
      req_hold_ms <= hold;
      req_elapsed_ms <= elapsed;
      req_last_in_frame <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly well-formed frames on a few busy channels, plus control ops and noise
   task automatic run_random_words(input int count);
      int sent, n, pick, delta;
      logic [3:0] ch;
      logic [15:0] hold, elapsed;
      logic [31:0] lvl, val;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            push_word(OP_FULL_RESET, 4'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 8) begin
            push_word(OP_CFG_CHANGED, 4'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 10) begin
            push_word(OP_UNUSED, 4'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 14) begin
            push_word(OP_SAMPLE, 4'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom), 1'($urandom));
            sent++;
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               ch = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
               if ($urandom_range(99) < 5) chan_level[ch] = $urandom;
               lvl = chan_level[ch];
               delta = $urandom_range(500);
               val = ($urandom_range(99) < 70) ? lvl + delta : lvl - 1 - delta;
               pick = $urandom_range(99);
               hold = (pick < 10) ? 16'd0 :
                      (pick < 80) ? 16'($urandom_range(1, 400)) : 16'($urandom);
               pick = $urandom_range(99);
               elapsed = (pick < 5) ? 16'd0 :
                         (pick < 85) ? 16'($urandom_range(1, 100)) : 16'($urandom);
               push_word(OP_SAMPLE, ch, val, lvl, hold, elapsed, k == n - 1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < CHANNELS; i++) chan_level[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed words, no idling
      // extreme over with hold 1 latches at once; extreme below closes the frame
      push_word(OP_SAMPLE, 4'd0, S_MAX, S_MIN, 16'd1, 16'd1, 1'b0);
      push_word(OP_SAMPLE, 4'd1, S_MIN, S_MAX, 16'hFFFF, 16'hFFFF, 1'b1);
      // equal value counts as over; zero hold means 1000 ms
      push_word(OP_SAMPLE, 4'd2, 32'h0001_8000, 32'h0001_8000, 16'd0, 16'd999, 1'b1);
      push_word(OP_SAMPLE, 4'd2, 32'h0001_8000, 32'h0001_8000, 16'd0, 16'd1, 1'b1);
      // zero elapsed time is ignored even when marked last
      push_word(OP_SAMPLE, 4'd2, 32'h0001_8000, 32'h0, 16'd5, 16'd0, 1'b1);
      // negative against zero, then triggering channel
      push_word(OP_SAMPLE, 4'd3, 32'hFFFF_FFFF, 32'h0, 16'd10, 16'd5, 1'b0);
      push_word(OP_SAMPLE, 4'd4, 32'h0, 32'hFFFF_FFFF, 16'd10, 16'd5, 1'b1);
      // config change clears timers, latches survive
      push_word(OP_CFG_CHANGED, 4'd4, 32'h0, 32'h0, 16'd0, 16'd0, 1'b1);
      push_word(OP_SAMPLE, 4'd4, 32'h0, 32'hFFFF_FFFF, 16'd10, 16'd6, 1'b1);
      push_word(OP_SAMPLE, 4'd2, S_MIN, S_MAX, 16'd10, 16'd6, 1'b1);
      // unused op does nothing
      push_word(OP_UNUSED, 4'd15, S_MAX, S_MIN, 16'hFFFF, 16'hFFFF, 1'b1);
      // long hold reached by two large steps, then stays latched while below
      push_word(OP_SAMPLE, 4'd15, S_MAX, S_MAX, 16'hFFFF, 16'd40000, 1'b0);
      push_word(OP_SAMPLE, 4'd15, S_MAX, S_MAX, 16'hFFFF, 16'd40000, 1'b1);
      push_word(OP_SAMPLE, 4'd15, S_MIN, S_MAX, 16'd1, 16'd1, 1'b1);
      // full reset, then everything starts over
      push_word(OP_FULL_RESET, 4'd0, 32'h0, 32'h0, 16'd0, 16'd0, 1'b1);
      push_word(OP_SAMPLE, 4'd0, S_MIN, S_MIN, 16'd2, 16'd1, 1'b1);
      push_word(OP_SAMPLE, 4'd7, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 1'b1);
      push_word(OP_SAMPLE, 4'd8, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 1'b0);
      push_word(OP_FULL_RESET, 4'd9, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF, 1'b0);
      push_word(OP_SAMPLE, 4'd0, 32'h0, 32'h0, 16'd3, 16'hFFFF, 1'b1);

      // random words across the idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         run_random_words(WORDS_PER_PHASE);
      end

      // drain and let the pipeline settle
      stall_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
